// ----- src/hkc_pkg.sv -----
// Shared types and constants for the hotkey chord detector.
package hkc_pkg;

   // Slot register layout
   localparam int NUM_REGS       = 8;
   localparam int REGS_PER_CHORD = 4;
   localparam int SLOT_W         = 21;
   localparam int CODE_W         = 10;
   localparam int EN_BIT         = 20;
   localparam int SLOT_IDX_W     = 3;
   localparam int EXIT_BASE      = 4;

   // Register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Event kind that carries a key
   localparam logic [4:0] KIND_KEY = 5'd1;

   typedef logic [NUM_REGS-1:0][SLOT_W-1:0] slot_array_type;

   localparam slot_array_type SLOT_RESET = '{
      21'd0, 21'd0, 21'd1162351, 21'd1176702,
      21'd0, 21'd1096751, 21'd1091638, 21'd1176702
   };

   typedef enum logic [1:0] {
      MAP_CLEAR,
      MAP_RUN,
      MAP_FETCH,
      MAP_LOAD
   } map_state_type;

   typedef struct packed {
      logic                  we;
      logic [SLOT_IDX_W-1:0] idx;
   } csr_write_type;

   typedef struct packed {
      logic              fire;
      logic [CODE_W-1:0] code;
      logic              down;
   } key_event_type;

   typedef struct packed {
      logic                  load;
      logic [SLOT_IDX_W-1:0] slot;
      logic                  prim_held;
      logic                  alt_held;
   } refresh_type;

endpackage

// ----- src/hkc_csr.sv -----
// Slot register file behind the APB-style configuration port.
module hkc_csr
   import hkc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output slot_array_type        slots,
   output csr_write_type         wr
);

   slot_array_type        slots_ff;
   logic [SLOT_IDX_W-1:0] idx;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   // Flag a completed write for the refresh logic
   assign wr.we  = csr_psel & csr_penable & csr_pwrite;
   assign wr.idx = idx;

   // Write the addressed slot
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOT_RESET;
      end else if (wr.we) begin
         slots_ff[idx] <= csr_pwdata[SLOT_W-1:0];
      end
   end

   // Read back the addressed slot
   assign csr_prdata = {{(CSR_DATA_W-SLOT_W){1'b0}}, slots_ff[idx]};
   assign slots      = slots_ff;

endmodule

// ----- src/hkc_keymap.sv -----
// Key bitmap memory with clearing pass and slot refresh sequencer.
module hkc_keymap
   import hkc_pkg::*;
#(
   parameter int KEY_SPACE_SIZE = 768
)
(
   input  logic           clock,
   input  logic           reset,
   input  slot_array_type slots,
   input  csr_write_type  wr,
   input  key_event_type  evt,
   output logic           map_ready,
   output refresh_type    refresh
);

   localparam int MAP_AW = $clog2(KEY_SPACE_SIZE);
   localparam logic [CODE_W:0] SLOT_LIMIT = (CODE_W+1)'(KEY_SPACE_SIZE);
   localparam logic [MAP_AW-1:0] LAST_ADDR = MAP_AW'(KEY_SPACE_SIZE - 1);

   logic mem [KEY_SPACE_SIZE];

   map_state_type         state_ff, state_in;
   logic [MAP_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [NUM_REGS-1:0]   pending_ff, pending_in;
   logic [SLOT_IDX_W-1:0] sel, sel_ff, sel_in;
   logic                  rd_prim_ff, rd_alt_ff;
   logic [CODE_W-1:0]     sel_prim, sel_alt, ld_prim, ld_alt;

   // Pick the lowest pending slot
   always_comb begin
      sel = '0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            sel = SLOT_IDX_W'(i);
         end
      end
   end

   assign sel_prim = slots[sel][2*CODE_W-1:CODE_W];
   assign sel_alt  = slots[sel][CODE_W-1:0];
   assign ld_prim  = slots[sel_ff][2*CODE_W-1:CODE_W];
   assign ld_alt   = slots[sel_ff][CODE_W-1:0];

   // Next state and outputs
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      pending_in = pending_ff;
      sel_in     = sel_ff;
      refresh    = '0;
      unique case (state_ff)
         MAP_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = (pending_ff != '0) ? MAP_FETCH : MAP_RUN;
            end
         end
         MAP_RUN: begin
            if (pending_ff != '0) begin
               state_in = MAP_FETCH;
            end
         end
         MAP_FETCH: begin
            pending_in[sel] = 1'b0;
            sel_in          = sel;
            state_in        = MAP_LOAD;
         end
         MAP_LOAD: begin
            refresh.load      = 1'b1;
            refresh.slot      = sel_ff;
            refresh.prim_held = rd_prim_ff & ({1'b0, ld_prim} < SLOT_LIMIT);
            refresh.alt_held  = rd_alt_ff & ({1'b0, ld_alt} < SLOT_LIMIT);
            state_in          = (pending_ff != '0) ? MAP_FETCH : MAP_RUN;
         end
         default: begin
            state_in = MAP_RUN;
         end
      endcase
      // A new write always re-arms its slot
      if (wr.we) begin
         pending_in[wr.idx] = 1'b1;
      end
   end

   assign map_ready = (state_ff == MAP_RUN) && (pending_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= MAP_CLEAR;
         clr_cnt_ff <= '0;
         pending_ff <= '0;
         sel_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         pending_ff <= pending_in;
         sel_ff     <= sel_in;
      end
   end

   // Write port: clearing pass or key event
   always_ff @(posedge clock) begin
      if (state_ff == MAP_CLEAR) begin
         mem[clr_cnt_ff] <= 1'b0;
      end else if (evt.fire) begin
         mem[evt.code[MAP_AW-1:0]] <= evt.down;
      end
   end

   // Read ports for slot refresh
   always_ff @(posedge clock) begin
      rd_prim_ff <= mem[sel_prim[MAP_AW-1:0]];
      rd_alt_ff  <= mem[sel_alt[MAP_AW-1:0]];
   end

endmodule

// ----- src/hkc_chord.sv -----
// Per-slot held flags, chord match and trigger edge detection.
module hkc_chord
   import hkc_pkg::*;
#(
   parameter int CHORD_SLOTS = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  slot_array_type slots,
   input  key_event_type  evt,
   input  refresh_type    refresh,
   output logic           trigger_hit,
   output logic           exit_hit
);

   localparam int USED = (CHORD_SLOTS < REGS_PER_CHORD) ? CHORD_SLOTS : REGS_PER_CHORD;

   logic [NUM_REGS-1:0] prim_ff, prim_in, alt_ff, alt_in;
   logic [NUM_REGS-1:0] slot_held, slot_en;
   logic                trig_any, trig_all, exit_any, exit_all, trig_now;
   logic                was_held_ff;

   // Apply refresh, then the current key event
   always_comb begin
      prim_in = prim_ff;
      alt_in  = alt_ff;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (refresh.load && refresh.slot == SLOT_IDX_W'(i)) begin
            prim_in[i] = refresh.prim_held;
            alt_in[i]  = refresh.alt_held;
         end
         if (evt.fire && slots[i][2*CODE_W-1:CODE_W] == evt.code) begin
            prim_in[i] = evt.down;
         end
         if (evt.fire && slots[i][CODE_W-1:0] == evt.code) begin
            alt_in[i] = evt.down;
         end
         slot_held[i] = prim_in[i] | alt_in[i];
         slot_en[i]   = slots[i][EN_BIT] && ((i % REGS_PER_CHORD) < USED);
      end
   end

   // Match each chord over its enabled slots
   always_comb begin
      trig_any = 1'b0;
      trig_all = 1'b1;
      exit_any = 1'b0;
      exit_all = 1'b1;
      for (int k = 0; k < REGS_PER_CHORD; k++) begin
         if (slot_en[k]) begin
            trig_any = 1'b1;
            trig_all = trig_all & slot_held[k];
         end
         if (slot_en[EXIT_BASE + k]) begin
            exit_any = 1'b1;
            exit_all = exit_all & slot_held[EXIT_BASE + k];
         end
      end
   end

   assign trig_now    = trig_any & trig_all;
   assign exit_hit    = evt.down & exit_any & exit_all;
   assign trigger_hit = ~exit_hit & trig_now & ~was_held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_ff     <= '0;
         alt_ff      <= '0;
         was_held_ff <= 1'b0;
      end else begin
         prim_ff <= prim_in;
         alt_ff  <= alt_in;
         // Exit leaves the trigger history alone
         if (evt.fire && !exit_hit) begin
            was_held_ff <= trig_now;
         end
      end
   end

endmodule

// ----- src/hotkey_chord_detector.sv -----
// Top level of the hotkey chord detector.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | event_kind, key_number, key_level
//   rsp     | out       | rsp_valid/ready    | trigger_pulse, exit_hit, event_ignored
//   csr     | in        | psel/penable/pwrite| paddr, pwdata, prdata (8 slot registers)
//
// One event per cycle unless stalled: input register, one pass of chord logic,
// result register; a held request waits until the result register frees.
// After reset the key bitmap memory is cleared entry by entry while req_ready is low.
// A lone slot register write holds req_ready low while its held flags reload.
// A stalled result holds while the input register still takes one more event.
module hotkey_chord_detector
   import hkc_pkg::*;
#(
   parameter int KEY_SPACE_SIZE = 768,
   parameter int CHORD_SLOTS    = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [4:0]            req_event_kind,
   input  logic [15:0]           req_key_number,
   input  logic [1:0]            req_key_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_trigger_pulse,
   output logic                  rsp_exit_hit,
   output logic                  rsp_event_ignored,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [16:0] KEY_LIMIT = 17'(KEY_SPACE_SIZE);

   slot_array_type slots;
   csr_write_type  wr;
   key_event_type  evt;
   refresh_type    refresh;
   logic           map_ready, advance, key_ok, trig_hit, exit_hit;

   logic        in_valid_ff;
   logic [4:0]  kind_ff;
   logic [15:0] key_ff;
   logic [1:0]  level_ff;
   logic        rsp_valid_ff, trig_ff, exit_ff, ign_ff;

   hkc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .slots       (slots),
      .wr          (wr)
   );

   hkc_keymap #(
      .KEY_SPACE_SIZE (KEY_SPACE_SIZE)
   ) u_keymap (
      .clock     (clock),
      .reset     (reset),
      .slots     (slots),
      .wr        (wr),
      .evt       (evt),
      .map_ready (map_ready),
      .refresh   (refresh)
   );

   hkc_chord #(
      .CHORD_SLOTS (CHORD_SLOTS)
   ) u_chord (
      .clock       (clock),
      .reset       (reset),
      .slots       (slots),
      .evt         (evt),
      .refresh     (refresh),
      .trigger_hit (trig_hit),
      .exit_hit    (exit_hit)
   );

   // Advance the held event when the result register frees up
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = map_ready & (~in_valid_ff | advance);

   // Decode the held event
   assign key_ok    = (kind_ff == KIND_KEY) && ({1'b0, key_ff} < KEY_LIMIT);
   assign evt.fire  = advance & key_ok;
   assign evt.code  = key_ff[CODE_W-1:0];
   assign evt.down  = (level_ff != 2'd0);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff  <= req_event_kind;
         key_ff   <= req_key_number;
         level_ff <= req_key_level;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trig_ff <= key_ok & trig_hit;
         exit_ff <= key_ok & exit_hit;
         ign_ff  <= ~key_ok;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_pulse = trig_ff;
   assign rsp_exit_hit      = exit_ff;
   assign rsp_event_ignored = ign_ff;

endmodule
